// File: src/c3zp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package c3zp_pkg;

  localparam int PIX_W       = 8;
  localparam int VAL_W       = 11;
  localparam int DIM_W       = 11;
  localparam int MODE_W      = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam logic [MODE_W-1:0] MODE_IDENTITY = 3'd0;
  localparam logic [MODE_W-1:0] MODE_BOX      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_GAUSS    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SOBEL_H  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SOBEL_V  = 3'd4;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd480;

  // floor(s/9) == (s*7282) >> 16 for every box sum up to 9*255
  localparam logic [12:0] BOX_RECIP   = 13'd7282;
  localparam int          BOX_SHIFT   = 16;
  localparam int          GAUSS_SHIFT = 4;

  localparam logic signed [VAL_W-1:0] SAT_MAX = 11'sd255;

  typedef logic [PIX_W-1:0] pix_t;

  // [row][col], row 0 is the upper image row
  typedef logic [2:0][2:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              pad_top;
    logic              pad_bot;
    logic              pad_left;
    logic              pad_right;
  } kctrl_t;

endpackage

`default_nettype wire

// File: src/c3zp_line_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module c3zp_line_mem import c3zp_pkg::*; #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  pix_t              wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output pix_t              rd_data
);

  pix_t mem [DEPTH];
  pix_t mem_q;
  pix_t fwd_data;
  logic fwd;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q    <= mem[rd_addr];
    // write-first when the same entry is written and read in one cycle
    fwd      <= wr_en && (wr_addr == rd_addr);
    fwd_data <= wr_data;
  end

  assign rd_data = fwd ? fwd_data : mem_q;

endmodule

`default_nettype wire

// File: src/c3zp_kernel.sv
`timescale 1ns / 1ps
`default_nettype none

module c3zp_kernel import c3zp_pkg::*; (
  input  win_t                     win,
  input  kctrl_t                   ctrl,
  output logic signed [VAL_W-1:0]  value
);

  logic [2:0][2:0][PIX_W-1:0] a;
  logic [2:0][9:0]            row_sum;
  logic [2:0][9:0]            row_g;
  logic [2:0][9:0]            col_g;
  logic [11:0]                box_sum;
  logic [11:0]                gauss_sum;
  logic [24:0]                box_prod;
  logic signed [VAL_W-1:0]    sob_h;
  logic signed [VAL_W-1:0]    sob_v;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if ((r == 0 && ctrl.pad_top) || (r == 2 && ctrl.pad_bot) ||
            (c == 0 && ctrl.pad_left) || (c == 2 && ctrl.pad_right)) begin
          a[r][c] = '0;
        end else begin
          a[r][c] = win[r][c];
        end
      end
    end

    for (int r = 0; r < 3; r++) begin
      row_sum[r] = 10'(a[r][0]) + 10'(a[r][1]) + 10'(a[r][2]);
      row_g[r]   = 10'(a[r][0]) + {1'b0, a[r][1], 1'b0} + 10'(a[r][2]);
    end
    for (int c = 0; c < 3; c++) begin
      col_g[c] = 10'(a[0][c]) + {1'b0, a[1][c], 1'b0} + 10'(a[2][c]);
    end

    box_sum   = 12'(row_sum[0]) + 12'(row_sum[1]) + 12'(row_sum[2]);
    gauss_sum = 12'(row_g[0]) + {1'b0, row_g[1], 1'b0} + 12'(row_g[2]);
    box_prod  = 25'(box_sum) * 25'(BOX_RECIP);

    sob_h = $signed({1'b0, row_g[0]}) - $signed({1'b0, row_g[2]});
    sob_v = $signed({1'b0, col_g[2]}) - $signed({1'b0, col_g[0]});

    unique case (ctrl.mode)
      MODE_BOX:     value = VAL_W'(box_prod[BOX_SHIFT +: PIX_W]);
      MODE_GAUSS:   value = VAL_W'(gauss_sum[GAUSS_SHIFT +: PIX_W]);
      MODE_SOBEL_H: value = (sob_h > SAT_MAX) ? SAT_MAX : sob_h;
      MODE_SOBEL_V: value = (sob_v > SAT_MAX) ? SAT_MAX : sob_v;
      default:      value = VAL_W'(a[1][1]);
    endcase
  end

endmodule

`default_nettype wire

// File: src/conv3x3_zero_pad_filter.sv
`timescale 1ns / 1ps
`default_nettype none

// Result path: the pixel completing a window loads the window and pending registers, then the
//   output register when not stalled (one row plus one pixel behind in the stream; flush items
//   drain the final row). Throughput: one item per cycle unless the output stalls, a recompute
//   runs or a write is offered; set by the single window update and the registered kernel.
// Reset (rst, synchronous) and every configuration write hold input off for the pixel-count
//   multiply plus a bit-serial divide of the output count. Line buffers are not cleared.

module conv3x3_zero_pad_filter import c3zp_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] pixel
  input  logic                   s_axis_tuser,   // [0] kind
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [10:0] value, [15:11] zero
  output logic                   m_axis_tlast,   // last_pixel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int COL_W  = (ADDR_W > DIM_W) ? ADDR_W : DIM_W;
  localparam int CNT_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int STEP_W = $clog2(CNT_W);

  typedef enum logic [2:0] {
    ST_TOTAL = 3'b001,
    ST_DIV   = 3'b010,
    ST_RUN   = 3'b100
  } seq_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (int'(v) > maxv) begin
      r = DIM_W'(maxv);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // configuration
  logic [MODE_W-1:0] filter_mode;
  logic [DIM_W-1:0]  w_dim;
  logic [DIM_W-1:0]  h_dim;
  logic [CNT_W-1:0]  total;
  logic              cfg_acc;

  // sequencer and divider
  seq_t              seq;
  logic [DIM_W-1:0]  div_rem;
  logic [CNT_W-1:0]  div_q;
  logic [STEP_W-1:0] div_step;
  logic [DIM_W:0]    rem_sh;
  logic              div_ge;
  logic [DIM_W-1:0]  div_rem_next;
  logic [CNT_W-1:0]  div_q_next;

  // position counters
  logic [COL_W-1:0]  in_col, in_col_next;
  logic [DIM_W-1:0]  in_row, in_row_next;
  logic [CNT_W-1:0]  out_count, out_count_next;
  logic [DIM_W-1:0]  out_row, out_row_next;
  logic [DIM_W-1:0]  out_col, out_col_next;

  // step
  logic              in_acc;
  logic              wrap_pre;
  logic [COL_W-1:0]  col0;
  logic [DIM_W-1:0]  row0;
  logic              in_image;
  logic              counts_done;
  logic              do_skip;
  logic              do_restart;
  logic              do_shift;
  logic              emit;
  logic              last;
  logic [COL_W-1:0]  col_inc;
  logic              col_end;
  logic [COL_W-1:0]  col_eff_next;
  pix_t              bot, mid, top;
  pix_t              rd_mid, rd_top;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  win_t              win;

  // result pipeline
  logic              p_valid;
  kctrl_t            p_ctrl;
  logic              p_last;
  logic              b_ok;
  logic              b_load;
  logic              out_valid;
  logic signed [VAL_W-1:0] out_value;
  logic              out_last;
  logic signed [VAL_W-1:0] k_value;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode <= MODE_IDENTITY;
      w_dim       <= clamp_dim(WIDTH_RESET, MAX_WIDTH);
      h_dim       <= clamp_dim(HEIGHT_RESET, MAX_HEIGHT);
    end else if (cfg_acc) begin
      unique case (cfg_index)
        REG_FILTER_MODE:  filter_mode <= cfg_data[MODE_W-1:0];
        REG_IMAGE_WIDTH:  w_dim       <= clamp_dim(cfg_data[DIM_W-1:0], MAX_WIDTH);
        REG_IMAGE_HEIGHT: h_dim       <= clamp_dim(cfg_data[DIM_W-1:0], MAX_HEIGHT);
        default: ;
      endcase
    end
  end

  // After reset or a write, recompute the pixel count and split out_count into row/column
  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= ST_TOTAL;
    end else if (cfg_acc) begin
      seq <= ST_TOTAL;
    end else begin
      unique case (seq)
        ST_TOTAL: seq <= ST_DIV;
        ST_DIV: begin
          if (div_step == '0) begin
            seq <= ST_RUN;
          end
        end
        ST_RUN: ;
        default: seq <= ST_TOTAL;
      endcase
    end
  end

  always_comb begin
    rem_sh       = {div_rem, div_q[CNT_W-1]};
    div_ge       = rem_sh >= {1'b0, w_dim};
    div_rem_next = div_ge ? DIM_W'(rem_sh - {1'b0, w_dim}) : rem_sh[DIM_W-1:0];
    div_q_next   = {div_q[CNT_W-2:0], div_ge};
  end

  always_ff @(posedge clk) begin
    if (seq == ST_TOTAL) begin
      total    <= CNT_W'({11'b0, w_dim} * {11'b0, h_dim});
      div_q    <= out_count;
      div_rem  <= '0;
      div_step <= STEP_W'(CNT_W - 1);
    end else if (seq == ST_DIV) begin
      div_q    <= div_q_next;
      div_rem  <= div_rem_next;
      div_step <= div_step - STEP_W'(1);
    end
  end

  // input side
  assign b_ok          = !out_valid || m_axis_tready;
  assign b_load        = p_valid && b_ok;
  assign s_axis_tready = (seq == ST_RUN) && !cfg_valid && (!p_valid || b_ok);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    // a column left beyond a narrowed width wraps to the next row first
    wrap_pre    = in_col >= COL_W'(w_dim);
    col0        = wrap_pre ? '0 : in_col;
    row0        = wrap_pre ? in_row + DIM_W'(1) : in_row;
    in_image    = row0 < h_dim;
    counts_done = out_count >= total;
    do_skip     = in_image && (s_axis_tuser == KIND_FLUSH);
    do_restart  = !in_image && counts_done;
    do_shift    = !do_skip && !do_restart;

    bot = (in_image && s_axis_tuser == KIND_PIXEL) ? s_axis_tdata[PIX_W-1:0] : '0;
    mid = (row0 != '0) ? rd_mid : '0;
    top = (row0 > DIM_W'(1)) ? rd_top : '0;

    col_inc = col0 + COL_W'(1);
    col_end = col_inc >= COL_W'(w_dim);
    emit    = do_shift && !counts_done &&
              ((row0 > DIM_W'(1)) || (row0 == DIM_W'(1) && col0 != '0));
    last    = (out_count + CNT_W'(1)) >= total;

    in_col_next    = in_col;
    in_row_next    = in_row;
    out_count_next = out_count;
    out_row_next   = out_row;
    out_col_next   = out_col;

    if (seq == ST_DIV && div_step == '0) begin
      out_row_next = DIM_W'(div_q_next);
      out_col_next = div_rem_next;
    end

    if (in_acc) begin
      priority if (do_restart) begin
        in_col_next    = '0;
        in_row_next    = '0;
        out_count_next = '0;
        out_row_next   = '0;
        out_col_next   = '0;
      end else if (do_skip) begin
        in_col_next = col0;
        in_row_next = row0;
      end else begin
        in_col_next = col_end ? '0 : col_inc;
        in_row_next = col_end ? row0 + DIM_W'(1) : row0;
        if (emit) begin
          if (last) begin
            in_col_next    = '0;
            in_row_next    = '0;
            out_count_next = '0;
            out_row_next   = '0;
            out_col_next   = '0;
          end else begin
            out_count_next = out_count + CNT_W'(1);
            if (out_col == w_dim - DIM_W'(1)) begin
              out_col_next = '0;
              out_row_next = out_row + DIM_W'(1);
            end else begin
              out_col_next = out_col + DIM_W'(1);
            end
          end
        end
      end
    end

    // line buffers are read ahead, through their registered read port, at the column the next item will use
    col_eff_next = (in_col_next >= COL_W'(w_dim)) ? '0 : in_col_next;
    rd_addr      = col_eff_next[ADDR_W-1:0];
    wr_en        = in_acc && do_shift;
    wr_addr      = col0[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col    <= '0;
      in_row    <= '0;
      out_count <= '0;
      out_row   <= '0;
      out_col   <= '0;
    end else begin
      in_col    <= in_col_next;
      in_row    <= in_row_next;
      out_count <= out_count_next;
      out_row   <= out_row_next;
      out_col   <= out_col_next;
    end
  end

  c3zp_line_mem #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (ADDR_W)
  ) u_mid_line (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (bot),
    .rd_addr (rd_addr),
    .rd_data (rd_mid)
  );

  c3zp_line_mem #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (ADDR_W)
  ) u_top_line (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (mid),
    .rd_addr (rd_addr),
    .rd_data (rd_top)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (wr_en) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= top;
      win[1][2] <= mid;
      win[2][2] <= bot;
    end
  end

  // pending stage: window registers plus the padding of the position being produced
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (in_acc) begin
      p_valid <= emit;
    end else if (b_ok) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      p_ctrl.mode      <= filter_mode;
      p_ctrl.pad_top   <= out_row == '0;
      p_ctrl.pad_bot   <= out_row == h_dim - DIM_W'(1);
      p_ctrl.pad_left  <= out_col == '0;
      p_ctrl.pad_right <= out_col == w_dim - DIM_W'(1);
      p_last           <= last;
    end
  end

  c3zp_kernel u_kernel (
    .win   (win),
    .ctrl  (p_ctrl),
    .value (k_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      out_value <= k_value;
      out_last  <= p_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_TDATA_W - VAL_W){1'b0}}, out_value};
  assign m_axis_tlast  = out_last;

endmodule

`default_nettype wire

// File: src/c3zp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module c3zp_checker import c3zp_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   s_axis_tready,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input wire logic                   m_axis_tlast,
  input wire logic                   cfg_valid,
  input wire logic                   cfg_ready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // reset starts the count recompute, so no input is taken right after it
  a_reset_busy: assert property (@(posedge clk)
    rst |=> !s_axis_tready)
    else $error("input ready right after reset");

  // a register write restarts the recompute
  a_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !s_axis_tready)
    else $error("input ready right after a register write");

  // filtered value saturates at 255 and stays within the sobel range below
  a_value_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      (m_axis_tdata[OUT_TDATA_W-1:VAL_W] == '0) &&
      ((m_axis_tdata[VAL_W-1] == 1'b0 && m_axis_tdata[VAL_W-2:PIX_W] == '0) ||
       (m_axis_tdata[VAL_W-1] == 1'b1 && m_axis_tdata[VAL_W-2:2] != '0)))
    else $error("filtered value out of range");

endmodule

bind conv3x3_zero_pad_filter c3zp_checker u_c3zp_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .cfg_valid     (cfg_valid),
  .cfg_ready     (cfg_ready)
);

`default_nettype wire
